/* rtl/assert_macros.svh */
// Assertion macros shared by the checker files.
// No dependencies; included by files that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SLX_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SLX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/slxfr_pkg.sv */
// Shared constants and types for the sync/length/XOR frame receiver.
// No dependencies.
`default_nettype none

package slxfr_pkg;

    localparam int unsigned MAX_PAYLOAD = 128;

    localparam logic [7:0]  SYNC_BYTE_RST = 8'hEF;
    localparam logic [15:0] TICKS_RST     = 16'd10;

    // Configuration register indexes
    localparam logic CFG_SYNC_BYTE = 1'b0;
    localparam logic CFG_TICKS     = 1'b1;

    // Input kinds
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Event codes
    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_SYNC    = 3'd1;
    localparam logic [2:0] EV_LEN_OK  = 3'd2;
    localparam logic [2:0] EV_LEN_BAD = 3'd3;
    localparam logic [2:0] EV_PAYLOAD = 3'd4;
    localparam logic [2:0] EV_GOOD    = 3'd5;
    localparam logic [2:0] EV_BAD     = 3'd6;
    localparam logic [2:0] EV_TIMEOUT = 3'd7;

    typedef struct packed {
        logic [6:0] byte_index;
        logic [7:0] data_byte;
        logic       in_frame;
        logic [2:0] event_res;
    } result_t;

endpackage

`default_nettype wire

/* rtl/sync_length_xor_frame_receiver.sv */
// Top level of the sync/length/XOR frame receiver: frame state machine,
// frame timer and a two-entry output buffer. Depends on slxfr_pkg.
//
//  channel  dir  tdata                                tuser
//  s_       in   [7:0] byte_value                     [0] command
//  m_       out  [7:0] data_byte, [14:8] byte_index   [2:0] event_res, [3] in_frame
//  cfg_     in   write port: [0] sync_byte, [1] ticks_per_byte
//
// One item per cycle while s_tready is high; its result is registered into the output buffer.
// The per-cycle path is the state update plus the 16x8 timer load multiply.
// Reset (synchronous, aresetn low) clears frame state, timer and buffer and
// restores the register defaults. A stalled output fills a second buffer
// slot; s_tready drops only while both slots hold results.
`default_nettype none

module sync_length_xor_frame_receiver
    import slxfr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_addr,
    input  wire logic [15:0] cfg_wr_data,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] byte_value
    input  wire logic [0:0]  s_tuser,   // [0] command

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] data_byte, [14:8] byte_index, [15] zero
    output logic [3:0]       m_tuser    // [2:0] event_res, [3] in_frame
);

    localparam logic [1:0] PH_SYNC  = 2'd0;
    localparam logic [1:0] PH_LEN   = 2'd1;
    localparam logic [1:0] PH_DATA  = 2'd2;
    localparam logic [1:0] PH_CHECK = 2'd3;

    localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

    logic [7:0]  sync_byte_reg;
    logic [15:0] ticks_reg;

    logic [1:0]  phase_reg,   phase_next;
    logic [7:0]  len_reg,     len_next;
    logic [7:0]  seen_reg,    seen_next;
    logic [7:0]  xor_reg,     xor_next;
    logic [23:0] timer_reg,   timer_next;
    logic        running_reg, running_next;

    result_t     res;
    result_t     out_reg, skid_reg;
    logic        out_valid_reg, skid_valid_reg;

    logic        accept, pop;
    logic [7:0]  b;
    logic [23:0] load_val;

    assign b        = s_tdata;
    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign pop      = out_valid_reg && m_tready;
    assign load_val = {8'd0, ticks_reg} * {16'd0, b};

    always_comb begin
        phase_next   = phase_reg;
        len_next     = len_reg;
        seen_next    = seen_reg;
        xor_next     = xor_reg;
        timer_next   = timer_reg;
        running_next = running_reg;
        res          = '{event_res: EV_NONE, in_frame: 1'b0, data_byte: 8'd0,
                         byte_index: 7'd0};

        if (s_tuser[0] == CMD_TICK) begin
            if (running_reg) begin
                if (timer_reg <= 24'd1) begin
                    timer_next    = 24'd0;
                    running_next  = 1'b0;
                    phase_next    = PH_SYNC;
                    res.event_res = EV_TIMEOUT;
                    res.data_byte = xor_reg;
                end else begin
                    timer_next = timer_reg - 24'd1;
                end
            end
        end else begin
            unique case (phase_reg)
                PH_SYNC: begin
                    if (b == sync_byte_reg) begin
                        phase_next    = PH_LEN;
                        res.event_res = EV_SYNC;
                        res.in_frame  = 1'b1;
                    end
                end
                PH_LEN: begin
                    if (b > MAX_LEN) begin
                        running_next  = 1'b0;
                        timer_next    = 24'd0;
                        phase_next    = PH_SYNC;
                        res.event_res = EV_LEN_BAD;
                    end else begin
                        len_next      = b;
                        seen_next     = 8'd0;
                        xor_next      = b;
                        timer_next    = load_val;
                        running_next  = 1'b1;
                        phase_next    = (b == 8'd0) ? PH_CHECK : PH_DATA;
                        res.event_res = EV_LEN_OK;
                        res.in_frame  = 1'b1;
                        res.data_byte = b;
                    end
                end
                PH_DATA: begin
                    res.event_res  = EV_PAYLOAD;
                    res.in_frame   = 1'b1;
                    res.data_byte  = b;
                    res.byte_index = seen_reg[6:0];
                    xor_next       = xor_reg ^ b;
                    seen_next      = seen_reg + 8'd1;
                    if (seen_next >= len_reg) begin
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    running_next  = 1'b0;
                    timer_next    = 24'd0;
                    phase_next    = PH_SYNC;
                    res.event_res = (b == xor_reg) ? EV_GOOD : EV_BAD;
                    res.in_frame  = 1'b1;
                    res.data_byte = xor_reg;
                end
                default: begin
                    phase_next = PH_SYNC;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_byte_reg <= SYNC_BYTE_RST;
            ticks_reg     <= TICKS_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_SYNC_BYTE: sync_byte_reg <= cfg_wr_data[7:0];
                CFG_TICKS:     ticks_reg     <= cfg_wr_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_SYNC;
            len_reg     <= 8'd0;
            seen_reg    <= 8'd0;
            xor_reg     <= 8'd0;
            timer_reg   <= 24'd0;
            running_reg <= 1'b0;
        end else if (accept) begin
            phase_reg   <= phase_next;
            len_reg     <= len_next;
            seen_reg    <= seen_next;
            xor_reg     <= xor_next;
            timer_reg   <= timer_next;
            running_reg <= running_next;
        end
    end

    // Two-slot output buffer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || pop) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= accept;
            end
        end else if (accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || pop) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (accept) begin
                out_reg <= res;
            end
        end else if (accept) begin
            skid_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg.byte_index, out_reg.data_byte};
    assign m_tuser  = {out_reg.in_frame, out_reg.event_res};

endmodule

`default_nettype wire

/* rtl/slxfr_checker.sv */
// Port-level checker for the frame receiver, bound to the top level.
// Depends on slxfr_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module slxfr_checker
    import slxfr_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic [3:0]  m_tuser
);

    `SLX_ASSERT_NEXT(a_valid_holds, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "result request dropped while stalled")
    `SLX_ASSERT_NEXT(a_data_holds, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
    `SLX_ASSERT_NOW(a_index_only_payload, aclk, aresetn, m_tvalid && (m_tuser[2:0] != EV_PAYLOAD), m_tdata[14:8] == 7'd0, "index set outside payload")
    `SLX_ASSERT_NOW(a_in_frame_code, aclk, aresetn, m_tvalid && (m_tuser[2:0] == EV_NONE || m_tuser[2:0] == EV_LEN_BAD || m_tuser[2:0] == EV_TIMEOUT), !m_tuser[3], "in_frame set on a dropped item")
    `SLX_ASSERT_NEXT(a_result_follows, aclk, aresetn, s_tvalid && s_tready, m_tvalid, "accepted request gave no result")

endmodule

bind sync_length_xor_frame_receiver slxfr_checker u_slxfr_checker (.*);

`default_nettype wire
